@@ src/humidity_sensor_frame_decoder_core_defines.svh @@
// Assertion macros shared by the checker of the sensor frame decoder.
// No dependencies; included by files that hold concurrent assertions.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hsfd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hsfd check failed");

`endif

@@ src/hsfd_pkg.sv @@
// Package of the sensor frame decoder: constants, job/result types, CRC-8 step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

    localparam logic [7:0]         CRC_POLY       = 8'h31;
    localparam logic [7:0]         CRC_INIT       = 8'hFF;
    localparam logic [14:0]        TEMP_SCALE     = 15'd17500;
    localparam logic [13:0]        HUM_SCALE      = 14'd10000;
    localparam logic signed [15:0] TEMP_OFFSET    = 16'sd4500;
    localparam logic [16:0]        RAW_FULL       = 17'd65535;
    localparam logic signed [14:0] TEMP_LOW_RST   = -15'sd4000;
    localparam logic signed [14:0] TEMP_HIGH_RST  = 15'sd8500;

    // configuration register indexes
    localparam logic REG_TEMP_LOW  = 1'b0;
    localparam logic REG_TEMP_HIGH = 1'b1;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 4;

    typedef struct packed {
        logic        ok;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
    } t_job;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic               valid_res;
    } t_result;

    // One byte through the CRC-8, MSB first, no final xor.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/hsfd_fifo.sv @@
// Small synchronous FIFO with registered storage and fill count.
// No dependencies; used for the job queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_data,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             is_full, wr, rd;

    assign is_full = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign wr      = i_push && !is_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ src/hsfd_front.sv @@
// Front end: byte framing, running CRC-8 checks, raw word capture.
// Depends on hsfd_pkg; emits one job per complete six-byte frame.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_first_byte,
    input  wire logic         i_bus_error,
    output logic              o_job_push,
    output hsfd_pkg::t_job    o_job
);

    localparam logic [2:0] BYTE_TEMP_MSB = 3'd0;
    localparam logic [2:0] BYTE_TEMP_LSB = 3'd1;
    localparam logic [2:0] BYTE_TEMP_CRC = 3'd2;
    localparam logic [2:0] BYTE_HUM_MSB  = 3'd3;
    localparam logic [2:0] BYTE_HUM_LSB  = 3'd4;

    logic [2:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_crc, n_crc;
    logic        r_temp_crc_good, n_temp_crc_good;
    logic        r_frame_fault, n_frame_fault;
    logic [15:0] r_temp_raw, n_temp_raw;
    logic [7:0]  r_hum_high, n_hum_high;
    logic [7:0]  r_hum_low, n_hum_low;

    logic [2:0]  cur_count;
    logic [7:0]  cur_crc, crc_next;
    logic        cur_good, cur_fault, last;

    // a first-byte marker drops any partial frame before this beat is used
    assign cur_count = i_first_byte ? '0 : r_byte_count;
    assign cur_crc   = i_first_byte ? hsfd_pkg::CRC_INIT : r_crc;
    assign cur_good  = i_first_byte ? 1'b0 : r_temp_crc_good;
    assign cur_fault = (i_first_byte ? 1'b0 : r_frame_fault) | i_bus_error;
    assign crc_next  = hsfd_pkg::crc_feed(cur_crc, i_data_byte);

    always_comb begin
        n_byte_count    = cur_count + 1'b1;
        n_crc           = cur_crc;
        n_temp_crc_good = cur_good;
        n_frame_fault   = cur_fault;
        n_temp_raw      = r_temp_raw;
        n_hum_high      = r_hum_high;
        n_hum_low       = r_hum_low;
        last            = 1'b0;
        case (cur_count)
            BYTE_TEMP_MSB: begin
                n_temp_raw = {i_data_byte, r_temp_raw[7:0]};
                n_crc      = crc_next;
            end
            BYTE_TEMP_LSB: begin
                n_temp_raw = {r_temp_raw[15:8], i_data_byte};
                n_crc      = crc_next;
            end
            BYTE_TEMP_CRC: begin
                n_temp_crc_good = (cur_crc == i_data_byte);
                n_crc           = hsfd_pkg::CRC_INIT;
            end
            BYTE_HUM_MSB: begin
                n_hum_high = i_data_byte;
                n_crc      = crc_next;
            end
            BYTE_HUM_LSB: begin
                n_hum_low = i_data_byte;
                n_crc     = crc_next;
            end
            default: begin
                // humidity CRC byte closes the frame
                last            = 1'b1;
                n_byte_count    = '0;
                n_crc           = hsfd_pkg::CRC_INIT;
                n_temp_crc_good = 1'b0;
                n_frame_fault   = 1'b0;
            end
        endcase
    end

    assign o_job_push     = i_accept && last;
    assign o_job.ok       = !cur_fault && cur_good && (cur_crc == i_data_byte);
    assign o_job.temp_raw = r_temp_raw;
    assign o_job.hum_raw  = {r_hum_high, r_hum_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_crc           <= hsfd_pkg::CRC_INIT;
            r_temp_crc_good <= 1'b0;
            r_frame_fault   <= 1'b0;
        end else if (i_accept) begin
            r_byte_count    <= n_byte_count;
            r_crc           <= n_crc;
            r_temp_crc_good <= n_temp_crc_good;
            r_frame_fault   <= n_frame_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_temp_raw <= n_temp_raw;
            r_hum_high <= n_hum_high;
            r_hum_low  <= n_hum_low;
        end
    end

endmodule

`default_nettype wire

@@ src/hsfd_back.sv @@
// Back end: scaling by constant multiply and divide-by-65535, limit check,
// result queue. Depends on hsfd_pkg and hsfd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module hsfd_back #(
    parameter int OUT_DEPTH = hsfd_pkg::OUT_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_empty,
    input  wire hsfd_pkg::t_job     i_job,
    output logic                    o_job_pop,
    input  wire logic signed [14:0] i_temp_low,
    input  wire logic signed [14:0] i_temp_high,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output hsfd_pkg::t_result       o_result
);

    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic        r_s1_v, r_s1_ok;
    logic [30:0] r_t_prod;
    logic [29:0] r_h_prod;
    logic        r_s2_v, r_s2_ok;
    logic [14:0] r_s2_tq;
    logic [13:0] r_s2_hq;

    logic [CW-1:0]      out_count;
    logic [CW:0]        pending;
    logic [14:0]        tq0, tq;
    logic [16:0]        tr;
    logic [13:0]        hq0, hq;
    logic [16:0]        hr;
    logic signed [15:0] temp_wide;
    logic signed [14:0] temp;
    hsfd_pkg::t_result  res;

    // credit: never launch more than the result queue can still hold
    assign pending   = (CW + 1)'(out_count) + (CW + 1)'(r_s1_v) + (CW + 1)'(r_s2_v);
    assign o_job_pop = !i_job_empty && (pending < (CW + 1)'(OUT_DEPTH));

    // x / 65535: x >> 16 is low by at most one; remainder is (x mod 2^16) + q0
    assign tq0 = r_t_prod[30:16];
    assign tr  = {1'b0, r_t_prod[15:0]} + {2'b0, tq0};
    assign tq  = tq0 + 15'(tr >= hsfd_pkg::RAW_FULL);
    assign hq0 = r_h_prod[29:16];
    assign hr  = {1'b0, r_h_prod[15:0]} + {3'b0, hq0};
    assign hq  = hq0 + 14'(hr >= hsfd_pkg::RAW_FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= o_job_pop;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1_ok  <= i_job.ok;
            r_t_prod <= 31'(hsfd_pkg::TEMP_SCALE) * 31'(i_job.temp_raw);
            r_h_prod <= 30'(hsfd_pkg::HUM_SCALE) * 30'(i_job.hum_raw);
        end
        if (r_s1_v) begin
            r_s2_ok <= r_s1_ok;
            r_s2_tq <= tq;
            r_s2_hq <= hq;
        end
    end

    assign temp_wide = $signed({1'b0, r_s2_tq}) - hsfd_pkg::TEMP_OFFSET;
    assign temp      = temp_wide[14:0];

    always_comb begin
        res.temperature_centi = '0;
        res.humidity_centi    = '0;
        res.valid_res         = 1'b0;
        if (r_s2_ok) begin
            res.temperature_centi = temp;
            res.humidity_centi    = r_s2_hq;
            res.valid_res         = (temp >= i_temp_low) && (temp <= i_temp_high);
        end
    end

    hsfd_fifo #(
        .WIDTH ($bits(hsfd_pkg::t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_v),
        .i_data  (res),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty),
        .o_count (out_count)
    );

endmodule

`default_nettype wire

@@ src/humidity_sensor_frame_decoder_core.sv @@
// The result of a frame passes the job queue, back-end stage 1 and stage 2 and the
// result queue before popping. Throughput: one byte per cycle; push stalls only
// while the job queue holds MID_DEPTH unstarted frames (back-end credit used up).
// Reset (synchronous, active low) clears framing, CRC, queues and both limit
// registers to their defaults of -40.00 and 85.00 degrees.
`timescale 1ns / 1ps
`default_nettype none

module humidity_sensor_frame_decoder_core #(
    parameter int MID_DEPTH = hsfd_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = hsfd_pkg::OUT_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_index,
    input  wire logic [14:0]        i_cfg_wdata,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_first_byte,
    input  wire logic               i_bus_error,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [14:0]      o_temperature_centi,
    output logic [13:0]             o_humidity_centi,
    output logic                    o_valid_res
);

    localparam int MCW = $clog2(MID_DEPTH + 1);

    logic signed [14:0] r_temp_low, r_temp_high;
    logic               accept, job_push, job_pop, job_empty;
    hsfd_pkg::t_job     job_in, job_out;
    hsfd_pkg::t_result  result;
    logic [MCW-1:0]     mid_count;

    assign accept = push && !full;
    assign full   = (mid_count == MCW'(MID_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_low  <= hsfd_pkg::TEMP_LOW_RST;
            r_temp_high <= hsfd_pkg::TEMP_HIGH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hsfd_pkg::REG_TEMP_LOW:  r_temp_low  <= $signed(i_cfg_wdata);
                hsfd_pkg::REG_TEMP_HIGH: r_temp_high <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    hsfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_bus_error  (i_bus_error),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    // job queue between framing and arithmetic
    hsfd_fifo #(
        .WIDTH ($bits(hsfd_pkg::t_job)),
        .DEPTH (MID_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty),
        .o_count (mid_count)
    );

    hsfd_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_temp_low  (r_temp_low),
        .i_temp_high (r_temp_high),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign o_temperature_centi = result.temperature_centi;
    assign o_humidity_centi    = result.humidity_centi;
    assign o_valid_res         = result.valid_res;

endmodule

`default_nettype wire

@@ src/hsfd_checker.sv @@
// Port-level checks for the sensor frame decoder, bound to the top level.
// Depends on humidity_sensor_frame_decoder_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "humidity_sensor_frame_decoder_core_defines.svh"

module hsfd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               push,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic signed [14:0] o_temperature_centi,
    input wire logic [13:0]        o_humidity_centi,
    input wire logic               o_valid_res
);

    // a waiting result beat holds until popped
    `HSFD_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_temperature_centi) && $stable(o_humidity_centi) && $stable(o_valid_res))

    // scaled values stay inside the sensor range
    `HSFD_ASSERT_NOW(a_result_range, i_clk, i_rst_n, !empty, (o_humidity_centi <= 14'd10000) && (o_temperature_centi >= -15'sd4500) && (o_temperature_centi <= 15'sd13000))

    // the job queue only fills on an accepted beat
    `HSFD_ASSERT_NOW(a_full_rise, i_clk, i_rst_n, $rose(full), $past(push))

    // results only drain through pop
    `HSFD_ASSERT_NOW(a_empty_rise, i_clk, i_rst_n, $rose(empty), $past(pop))

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker (.*);

`default_nettype wire
